/* rtl/lcdnf_pkg.sv */
package lcdnf_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned POS_W = 4;
	localparam int unsigned BCD_MAX = 5;

	localparam logic [2:0] OP_CHAR = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_SDEC = 3'd2;
	localparam logic [2:0] OP_HEX = 3'd3;
	localparam logic [2:0] OP_BIN = 3'd4;

	localparam logic [7:0] CMD_SET_CURSOR = 8'h80;
	localparam logic [7:0] LINE2_OFFSET = 8'h40;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_A = 8'h41;
	localparam logic [7:0] ASCII_PLUS = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] line;
		logic [5:0] column;
		logic [VALUE_W-1:0] value;
		logic [4:0] digit_count;
	} req_t;

	typedef struct packed {
		logic is_data;
		logic [7:0] lcd_byte;
		logic last;
	} result_t;

	// Everything the output sequencer needs for one request.
	typedef struct packed {
		logic [7:0] cmd;
		logic has_pre;
		logic [7:0] pre;
		logic [2:0] op;
		logic [CNT_W-1:0] n_dig;
		logic [POS_W-1:0] lead_k;
		logic [VALUE_W-1:0] value;
		logic [BCD_MAX-1:0][3:0] digits;
	} job_t;

	typedef enum logic [2:0] {
		PH_CMD = 3'b001,
		PH_PRE = 3'b010,
		PH_DIG = 3'b100
	} phase_t;

	// Powers of ten reduced modulo 256.
	function automatic logic [7:0] pow10_mod8(input logic [2:0] e);
		logic [7:0] r;
		begin
			unique case (e)
				3'd0: r = 8'd1;
				3'd1: r = 8'd10;
				3'd2: r = 8'd100;
				3'd3: r = 8'd232;
				3'd4: r = 8'd16;
				default: r = 8'd0;
			endcase
			return r;
		end
	endfunction

endpackage

/* rtl/lcdnf_bcd_cell.sv */
module lcdnf_bcd_cell
	import lcdnf_pkg::*;
(
	input  logic       clk,
	input  logic       clear,
	input  logic       shift,
	input  logic       bit_in,
	output logic [3:0] digit,
	output logic       carry_out
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add three before the shift so the digit never leaves the decimal range.
	assign adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = adj[3];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (clear) begin
			digit_q <= 4'd0;
		end else if (shift) begin
			digit_q <= {adj[2:0], bit_in};
		end
	end

endmodule

/* rtl/lcdnf_emit.sv */
module lcdnf_emit
	import lcdnf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  job_t    job,
	output logic    ready,
	output logic    strobe,
	output result_t result
);

	logic occ_q;
	phase_t phase_q;
	logic [POS_W-1:0] k_q;
	job_t job_q;
	logic strobe_q;
	result_t result_q;

	result_t cur;
	phase_t nxt_phase;
	logic [POS_W-1:0] nxt_k;
	logic more;

	logic is_lead;
	logic [3:0] dec_d;
	logic [7:0] lead_dec;
	logic [VALUE_W-1:0] bin_sh;
	logic [3:0] nib;
	logic [7:0] dig_byte;
	logic [POS_W-1:0] first_k;

	assign is_lead = (k_q == job_q.lead_k);
	assign first_k = POS_W'(job_q.n_dig - CNT_W'(1));

	always_comb begin
		lead_dec = 8'd0;
		for (int j = 0; j < BCD_MAX; j++) begin
			if (POS_W'(j) >= k_q) begin
				lead_dec = lead_dec
					+ 8'({4'd0, job_q.digits[j]} * pow10_mod8(3'(j) - k_q[2:0]));
			end
		end
	end

	assign dec_d = (k_q < POS_W'(BCD_MAX)) ? job_q.digits[k_q[2:0]] : 4'd0;
	assign bin_sh = job_q.value >> k_q;
	assign nib = (k_q < POS_W'(4)) ? job_q.value[{k_q[1:0], 2'b00} +: 4] : 4'd0;

	always_comb begin
		unique case (job_q.op)
			OP_UDEC, OP_SDEC: begin
				dig_byte = ASCII_ZERO + (is_lead ? lead_dec : {4'd0, dec_d});
			end
			OP_HEX: begin
				dig_byte = (nib < 4'd10) ? ASCII_ZERO + {4'd0, nib}
					: ASCII_A + {4'd0, nib} - 8'd10;
			end
			OP_BIN: begin
				dig_byte = ASCII_ZERO + (is_lead ? bin_sh[7:0] : {7'd0, job_q.value[k_q]});
			end
			default: begin
				dig_byte = ASCII_ZERO;
			end
		endcase
	end

	always_comb begin
		cur = '0;
		nxt_phase = phase_q;
		nxt_k = k_q;
		more = 1'b0;
		unique case (phase_q)
			PH_CMD: begin
				cur.is_data = 1'b0;
				cur.lcd_byte = job_q.cmd;
				if (job_q.has_pre) begin
					more = 1'b1;
					nxt_phase = PH_PRE;
				end else if (job_q.n_dig != '0) begin
					more = 1'b1;
					nxt_phase = PH_DIG;
					nxt_k = first_k;
				end
			end
			PH_PRE: begin
				cur.is_data = 1'b1;
				cur.lcd_byte = job_q.pre;
				if (job_q.n_dig != '0) begin
					more = 1'b1;
					nxt_phase = PH_DIG;
					nxt_k = first_k;
				end
			end
			PH_DIG: begin
				cur.is_data = 1'b1;
				cur.lcd_byte = dig_byte;
				if (k_q != '0) begin
					more = 1'b1;
					nxt_k = k_q - POS_W'(1);
				end
			end
			default: begin
				cur = '0;
			end
		endcase
		cur.last = !more;
	end

	assign ready = !occ_q || !more;
	assign strobe = strobe_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			phase_q <= PH_CMD;
			k_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= occ_q;
			if (load) begin
				occ_q <= 1'b1;
				phase_q <= PH_CMD;
			end else if (occ_q) begin
				if (!more) begin
					occ_q <= 1'b0;
				end else begin
					phase_q <= nxt_phase;
					k_q <= nxt_k;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
		if (occ_q) begin
			result_q <= cur;
		end
	end

endmodule

/* rtl/char_lcd_number_formatter.sv */
// Character-display number formatter.
// A request is taken on a clock edge where start is high and busy is low. It
// carries an operation (character, unsigned, signed, hex or binary), a line, a
// column, a value and a digit count. The block answers with a cursor command
// byte and then the ASCII data bytes, one byte per cycle on result, each marked
// by strobe for exactly one cycle; last flags the final byte of a request.
// A request's value, VALUE_BITS wide (capped at 16), is first converted in a
// row of BCD digit cells with shift-and-add-three, one bit per cycle. It then
// moves to the output sequencer once that is idle or on the last byte of the
// previous request. busy is high after acceptance while the conversion runs,
// and longer only while the sequencer has not yet reached the last byte of the
// previous request; so the next request is converted while the previous one
// is still being sent. A request yields one to MAX_DIGITS + 2 bytes; the rate
// of requests is bounded by the conversion row and the single byte-wide
// output. The receiver cannot stall; every strobed byte is taken.
// Reset clears all control state: nothing is in flight and busy is low.
module char_lcd_number_formatter
	import lcdnf_pkg::*;
#(
	parameter int MAX_DIGITS = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  req_t    req,
	output logic    strobe,
	output result_t result
);

	localparam int unsigned VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam bit HAS_SIGN = (VALUE_BITS <= VALUE_W);
	localparam int unsigned ND = (VW > 13) ? 5 : ((VW > 9) ? 4 : 3);
	localparam int unsigned CCW = $clog2(VW + 1);
	localparam logic [VALUE_W-1:0] VMASK = VALUE_W'((33'h1 << VW) - 33'h1);

	logic accept;
	logic [VALUE_W-1:0] vm;
	logic neg;
	logic [VALUE_W-1:0] mag;
	logic [CNT_W-1:0] cnt;
	logic hex_skip;
	job_t new_job;
	logic [VW-1:0] conv_val;

	logic conv_occ_q;
	logic [CCW-1:0] conv_cnt_q;
	logic [VW-1:0] conv_sr_q;
	job_t pend_q;

	logic conv_done;
	logic shift;
	logic emit_ready;
	logic handoff;
	job_t emit_job;

	logic [ND-1:0][3:0] cell_d;
	logic [ND-2:0] cell_co;

	assign accept = start && !busy;
	assign busy = conv_occ_q;

	assign vm = req.value & VMASK;
	assign neg = HAS_SIGN && vm[VW-1];
	assign mag = (~vm + VALUE_W'(1)) & VMASK;
	assign cnt = (req.digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
		: req.digit_count;
	assign hex_skip = ((vm >> {cnt, 2'b00}) != '0);
	assign conv_val = (req.op == OP_SDEC && neg) ? mag[VW-1:0] : vm[VW-1:0];

	always_comb begin
		new_job = '0;
		new_job.cmd = CMD_SET_CURSOR + {2'b00, req.column} - 8'd1
			+ ((req.line != 2'd1) ? LINE2_OFFSET : 8'd0);
		new_job.op = req.op;
		new_job.value = vm;
		new_job.lead_k = POS_W'(cnt - CNT_W'(1));
		new_job.has_pre = (req.op == OP_CHAR) || (req.op == OP_SDEC);
		new_job.pre = (req.op == OP_CHAR) ? vm[7:0] : (neg ? ASCII_MINUS : ASCII_PLUS);
		unique case (req.op)
			OP_UDEC, OP_SDEC, OP_BIN: new_job.n_dig = cnt;
			// A leading hex quotient above fifteen prints nothing.
			OP_HEX: new_job.n_dig = (cnt != '0 && hex_skip) ? cnt - CNT_W'(1) : cnt;
			default: new_job.n_dig = '0;
		endcase
	end

	assign conv_done = conv_occ_q && (conv_cnt_q == '0);
	assign shift = conv_occ_q && (conv_cnt_q != '0);
	assign handoff = conv_done && emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_occ_q <= 1'b0;
			conv_cnt_q <= '0;
		end else begin
			if (accept) begin
				conv_occ_q <= 1'b1;
				conv_cnt_q <= CCW'(VW);
			end else if (shift) begin
				conv_cnt_q <= conv_cnt_q - CCW'(1);
			end else if (handoff) begin
				conv_occ_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			conv_sr_q <= conv_val;
			pend_q <= new_job;
		end else if (shift) begin
			conv_sr_q <= conv_sr_q << 1;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < ND; gi++) begin : g_cell
			logic bit_in;
			if (gi == 0) begin : g_first
				assign bit_in = conv_sr_q[VW-1];
			end else begin : g_next
				assign bit_in = cell_co[gi-1];
			end
			if (gi == ND - 1) begin : g_top
				lcdnf_bcd_cell u_cell (
					.clk       (clk),
					.clear     (accept),
					.shift     (shift),
					.bit_in    (bit_in),
					.digit     (cell_d[gi]),
					.carry_out ()
				);
			end else begin : g_mid
				lcdnf_bcd_cell u_cell (
					.clk       (clk),
					.clear     (accept),
					.shift     (shift),
					.bit_in    (bit_in),
					.digit     (cell_d[gi]),
					.carry_out (cell_co[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		emit_job = pend_q;
		emit_job.digits = '0;
		for (int i = 0; i < ND; i++) begin
			emit_job.digits[i] = cell_d[i];
		end
	end

	lcdnf_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (handoff),
		.job    (emit_job),
		.ready  (emit_ready),
		.strobe (strobe),
		.result (result)
	);

endmodule
